// ===== hw/rtl/gateway_line_parser_macros.svh =====
// Assertion helpers for the line parser.
`ifndef GATEWAY_LINE_PARSER_MACROS_SVH
`define GATEWAY_LINE_PARSER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define GWLP_ASSERT_NOW(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define GWLP_ASSERT_NEXT(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/gwlp_pkg.sv =====
`default_nettype none

package gwlp_pkg;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [2:0] DIR_THERMOSTAT    = 3'd0;
   localparam logic [2:0] DIR_BOILER        = 3'd1;
   localparam logic [2:0] DIR_TO_BOILER     = 3'd2;
   localparam logic [2:0] DIR_TO_THERMOSTAT = 3'd3;
   localparam logic [2:0] DIR_ERROR         = 3'd4;
   localparam logic [2:0] DIR_UNEXPECTED    = 3'd5;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_B       = 8'h42;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_E       = 8'h45;

   localparam int          ERR_KINDS     = 5;
   localparam logic [2:0]  KIND_GENERIC  = 3'd0;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam int          RSP_BITS      = 56;

   // Summary of one finished line, handed from the parser to the top level.
   typedef struct packed {
      logic       done;
      logic       err_line;
      logic [2:0] error_kind;
      logic [2:0] direction;
      logic [2:0] msg_type;
      logic [7:0] data_id;
      logic [15:0] data_value;
      logic       timed_out;
   } line_end_type;

   // Result word, lowest field at the bottom.
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] error_count;
      logic [2:0]  error_kind;
      logic        timed_out;
      logic [15:0] data_value;
      logic [7:0]  data_id;
      logic [2:0]  msg_type;
      logic [2:0]  direction;
   } rsp_type;

   // Returns {is_digit, value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Letters of the error prefix by position.
   function automatic logic [7:0] err_letter(input logic [2:0] pos);
      logic [7:0] r;
      unique case (pos)
         3'd0:    r = 8'h45;
         3'd1:    r = 8'h72;
         3'd2:    r = 8'h72;
         3'd3:    r = 8'h6F;
         3'd4:    r = 8'h72;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] field_width(input logic [1:0] f);
      return (f == 2'd2) ? 3'd4 : 3'd2;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gwlp_err_counters.sv =====
`default_nettype none

module gwlp_err_counters
   import gwlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        bump,
   input  wire logic [2:0]  kind,
   output logic      [15:0] count_new
);

   logic [15:0] count_ff [ERR_KINDS];
   logic [15:0] count_cur;

   always_comb begin
      count_cur = (kind < 3'(ERR_KINDS)) ? count_ff[kind] : 16'd0;
      count_new = (count_cur == COUNT_MAX) ? count_cur : count_cur + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ERR_KINDS; i++) begin
            count_ff[i] <= 16'd0;
         end
      end else if (bump && kind < 3'(ERR_KINDS)) begin
         count_ff[kind] <= count_new;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gwlp_parse_core.sv =====
`default_nettype none

module gwlp_parse_core
   import gwlp_pkg::*;
#(
   parameter int LINE_CHARS = 63
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step_en,
   input  wire logic        op,
   input  wire logic [7:0]  char_code,
   input  wire logic [15:0] timeout_ticks,
   output line_end_type     line_end
);

   localparam int LenWidth = $clog2(LINE_CHARS + 1);
   localparam logic [LenWidth-1:0] LenLast = LenWidth'(LINE_CHARS - 1);

   logic [LenWidth-1:0] len_ff, len_in, w_len;
   logic [15:0] idle_ff, idle_in, w_idle;
   logic [7:0]  lead_ff, lead_in, w_lead;
   logic [2:0]  pm_ff, pm_in, w_pm;
   logic [1:0]  fnum_ff, fnum_in, w_f;
   logic [2:0]  dc_ff, dc_in, w_dc;
   logic [7:0]  type_ff, type_in, w_type;
   logic [7:0]  id_ff, id_in, w_id;
   logic [15:0] value_ff, value_in, w_value;
   logic        fail_ff, fail_in, w_fail;
   logic [3:0]  code_ff, code_in, w_code;

   always_comb begin
      logic [4:0] hx;
      logic       dv;
      logic [3:0] d;
      logic       printable;
      logic       tick_out;
      logic       full;
      logic       fin;
      logic       go;
      logic [1:0] fcur;
      logic       ok;

      hx        = hex_digit(char_code);
      dv        = hx[4];
      d         = hx[3:0];
      printable = (op == OP_CHAR) && (char_code >= CHAR_SPACE);
      tick_out  = 1'b0;
      full      = 1'b0;
      go        = 1'b0;
      fcur      = fnum_ff;
      ok        = 1'b0;

      w_len = len_ff;  w_idle = idle_ff; w_lead = lead_ff; w_pm = pm_ff;
      w_f = fnum_ff;   w_dc = dc_ff;     w_type = type_ff; w_id = id_ff;
      w_value = value_ff; w_fail = fail_ff; w_code = code_ff;

      if (op == OP_TICK) begin
         if (idle_ff != COUNT_MAX) begin
            w_idle = idle_ff + 16'd1;
         end
         tick_out = w_idle > timeout_ticks;
      end else if (printable) begin
         if (len_ff == '0) begin
            w_lead = char_code;
         end
         if (len_ff < LenWidth'(5) && pm_ff == len_ff[2:0] &&
             char_code == err_letter(len_ff[2:0])) begin
            w_pm = pm_ff + 3'd1;
         end
         if (w_pm == 3'd5) begin
            if (len_ff == LenWidth'(4)) begin
               w_f = 2'd0; w_dc = 3'd0; w_fail = 1'b0; w_code = 4'd0;
            end else if (len_ff >= LenWidth'(6)) begin
               // error code digits
               if (fnum_ff < 2'd2 && !(fnum_ff == 2'd0 && char_code == CHAR_SPACE)) begin
                  if (!dv) begin
                     w_f = 2'd2;
                  end else begin
                     w_f  = 2'd1;
                     w_dc = 3'd1;
                     if (code_ff != 4'd0) begin
                        w_fail = 1'b1;
                     end else begin
                        w_code = d;
                     end
                  end
               end
            end
         end else if (len_ff != '0) begin
            // hex message fields
            if (!fail_ff && fnum_ff != 2'd3) begin
               if (dc_ff != 3'd0 && dv) begin
                  case (fnum_ff)
                     2'd0:    w_type  = {type_ff[3:0], d};
                     2'd1:    w_id    = {id_ff[3:0], d};
                     default: w_value = {value_ff[11:0], d};
                  endcase
                  w_dc = dc_ff + 3'd1;
                  if (w_dc >= field_width(fnum_ff)) begin
                     w_f  = fnum_ff + 2'd1;
                     w_dc = 3'd0;
                  end
               end else begin
                  go = 1'b1;
                  if (dc_ff != 3'd0) begin
                     fcur = fnum_ff + 2'd1;
                     w_f  = fcur;
                     w_dc = 3'd0;
                     go   = (fcur != 2'd3);
                  end
                  if (go && char_code != CHAR_SPACE) begin
                     if (!dv) begin
                        w_fail = 1'b1;
                     end else begin
                        case (fcur)
                           2'd0:    w_type  = {4'd0, d};
                           2'd1:    w_id    = {4'd0, d};
                           default: w_value = {12'd0, d};
                        endcase
                        w_dc = 3'd1;
                     end
                  end
               end
            end
         end
         w_len = len_ff + LenWidth'(1);
         full  = len_ff >= LenLast;
      end

      fin = ((op == OP_CHAR) && (char_code == CHAR_NEWLINE)) || (printable && full);

      line_end = '0;
      line_end.direction = DIR_UNEXPECTED;
      if (tick_out) begin
         line_end.done      = 1'b1;
         line_end.timed_out = 1'b1;
      end else if (fin) begin
         line_end.done = 1'b1;
         if (w_pm == 3'd5) begin
            line_end.err_line  = 1'b1;
            line_end.direction = DIR_ERROR;
            if (w_dc != 3'd0 && !w_fail && w_code >= 4'd1 && w_code <= 4'd4) begin
               line_end.error_kind = w_code[2:0];
            end else begin
               line_end.error_kind = KIND_GENERIC;
            end
         end else begin
            ok = !w_fail && (w_f == 2'd3 || (w_f == 2'd2 && w_dc != 3'd0));
            if (ok) begin
               line_end.msg_type   = w_type[6:4];
               line_end.data_id    = w_id;
               line_end.data_value = w_value;
               case (w_lead)
                  CHAR_T:  line_end.direction = DIR_THERMOSTAT;
                  CHAR_B:  line_end.direction = DIR_BOILER;
                  CHAR_R:  line_end.direction = DIR_TO_BOILER;
                  CHAR_A:  line_end.direction = DIR_TO_THERMOSTAT;
                  CHAR_E:  line_end.direction = DIR_ERROR;
                  default: line_end.direction = DIR_UNEXPECTED;
               endcase
            end
         end
      end

      if (line_end.done) begin
         len_in = '0; idle_in = 16'd0; lead_in = 8'd0; pm_in = 3'd0; fnum_in = 2'd0;
         dc_in = 3'd0; type_in = 8'd0; id_in = 8'd0; value_in = 16'd0;
         fail_in = 1'b0; code_in = 4'd0;
      end else begin
         len_in = w_len; idle_in = w_idle; lead_in = w_lead; pm_in = w_pm; fnum_in = w_f;
         dc_in = w_dc; type_in = w_type; id_in = w_id; value_in = w_value;
         fail_in = w_fail; code_in = w_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; idle_ff <= 16'd0; lead_ff <= 8'd0; pm_ff <= 3'd0; fnum_ff <= 2'd0;
         dc_ff <= 3'd0; type_ff <= 8'd0; id_ff <= 8'd0; value_ff <= 16'd0;
         fail_ff <= 1'b0; code_ff <= 4'd0;
      end else if (step_en) begin
         len_ff <= len_in; idle_ff <= idle_in; lead_ff <= lead_in; pm_ff <= pm_in;
         fnum_ff <= fnum_in; dc_ff <= dc_in; type_ff <= type_in; id_ff <= id_in;
         value_ff <= value_in; fail_ff <= fail_in; code_ff <= code_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gateway_line_parser.sv =====
// Line parser for a heating gateway's serial text. Each req transaction
// carries one received character (tuser 0) or one idle poll tick (tuser 1).
// Control characters are dropped; newline, a full line of LINE_CHARS
// characters, or more idle ticks than csr_data last set (reset 100) end the
// line and produce exactly one rsp transaction. "Error" lines bump one of five
// saturating error counters; other lines yield direction, message type, data
// id and value from three hex fields. The block takes one item per clock
// cycle: an input register feeds the combinational parse update, whose result
// lands in the output register when that register can take it. That output
// register is the only stall point; req_tready drops only while it holds a
// result the consumer has not taken. Write csr_data only while idle.
`default_nettype none

module gateway_line_parser
   import gwlp_pkg::*;
#(
   parameter int LINE_CHARS = 63
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input item stream
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,  // [7:0] char_code
   input  wire logic [0:0]          req_tuser,  // [0] operation
   // result stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [2:0] direction, [5:3] msg_type, [13:6] data_id, [29:14] data_value,
   // [30] timed_out, [33:31] error_kind, [49:34] error_count, [55:50] zero
   output logic [RSP_BITS-1:0]      rsp_tdata,
   // timeout register write
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [15:0]         csr_data
);

`include "gateway_line_parser_macros.svh"

   logic         in_valid_ff, in_valid_in;
   logic         in_op_ff;
   logic [7:0]   in_char_ff;
   logic         advance;
   logic [15:0]  timeout_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   line_end_type line_end;
   logic [15:0]  count_new;

   // Advance the held item whenever the output register can take a result.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   gwlp_parse_core #(
      .LINE_CHARS (LINE_CHARS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .op            (in_op_ff),
      .char_code     (in_char_ff),
      .timeout_ticks (timeout_ff),
      .line_end      (line_end)
   );

   gwlp_err_counters u_counters (
      .clock     (clock),
      .reset     (reset),
      .bump      (advance && line_end.done && line_end.err_line),
      .kind      (line_end.error_kind),
      .count_new (count_new)
   );

   always_comb begin
      // Hold the input register until the parse step consumes it.
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      // Load a result on a line end; drop valid once the consumer takes it.
      if (advance) begin
         rsp_valid_in = line_end.done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_in             = '0;
      rsp_in.direction   = line_end.direction;
      rsp_in.msg_type    = line_end.msg_type;
      rsp_in.data_id     = line_end.data_id;
      rsp_in.data_value  = line_end.data_value;
      rsp_in.timed_out   = line_end.timed_out;
      rsp_in.error_kind  = line_end.error_kind;
      rsp_in.error_count = line_end.err_line ? count_new : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser[0];
         in_char_ff <= req_tdata;
      end
      if (advance && line_end.done) begin
         rsp_ff <= rsp_in;
      end
   end

   `GWLP_ASSERT_NEXT(a_item_not_lost, clock, reset, in_valid_ff && !advance, in_valid_ff,
      "held item dropped before parse step")
   `GWLP_ASSERT_NEXT(a_line_end_shown, clock, reset, advance && line_end.done, rsp_valid_ff,
      "line end produced no result")
   `GWLP_ASSERT_NOW(a_kind_on_error, clock, reset,
      rsp_valid_ff && rsp_ff.error_kind != KIND_GENERIC, rsp_ff.direction == DIR_ERROR,
      "error kind set on non-error line")
   `GWLP_ASSERT_NOW(a_timeout_clean, clock, reset, rsp_valid_ff && rsp_ff.timed_out,
      rsp_ff.direction == DIR_UNEXPECTED && rsp_ff.error_count == 16'd0,
      "timeout result not clean")

endmodule

`default_nettype wire
